@@ src/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Command and status codes, and the record types that travel down the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD   = 3'd0;
  localparam cmd_t CMD_SUB   = 3'd1;
  localparam cmd_t CMD_MUL   = 3'd2;
  localparam cmd_t CMD_CDIV  = 3'd3;
  localparam cmd_t CMD_SCALE = 3'd4;
  localparam cmd_t CMD_RDIV  = 3'd5;
  localparam cmd_t CMD_CONJ  = 3'd6;
  localparam cmd_t CMD_MOD   = 3'd7;

  typedef logic [1:0] stat_t;

  localparam stat_t STAT_OK  = 2'd0;
  localparam stat_t STAT_DZ  = 2'd1;
  localparam stat_t STAT_SAT = 2'd2;

  // One quotient bit per division lane and one root bit are produced per stage.
  localparam int ITER_STAGES = 32;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    div_lane_t   re;
    div_lane_t   im;
    logic [63:0] den;
    sqrt_lane_t  sq;
  } iter_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [31:0] dir_re;
    logic [31:0] dir_im;
  } ctrl_t;

endpackage

`default_nettype wire

@@ src/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex ALU on signed fixed-point operands: add, subtract,
// multiply, divide, scale, real divide, conjugate and modulus.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the 32
// quotient/root stages retire one bit each, and every stage holds one item.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset (rst_n low, synchronous) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [2:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // result_re, result_im
  output logic [1:0]        out_tuser   // status
);

  // All stages advance together whenever the output register can take a
  // new transfer. An empty output register always lets the pipe move.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic wide_t sx32(logic signed [31:0] x);
    return $signed({{34{x[31]}}, x});
  endfunction

  function automatic wide_t sx64(logic signed [63:0] x);
    return $signed({{2{x[63]}}, x});
  endfunction

  // Clamp a wide signed value into 32 bits; bit 32 flags a clamp.
  function automatic logic [32:0] sat_wide(wide_t v);
    logic fits;
    fits = (&v[65:31]) || !(|v[65:31]);
    if (fits) begin
      return {1'b0, v[31:0]};
    end
    return {1'b1, v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF};
  endfunction

  // Apply sign to a quotient magnitude and clamp; bit 32 flags a clamp.
  function automatic logic [32:0] sat_quo(logic neg, logic [31:0] q, logic ovf);
    logic clamp;
    clamp = ovf || (!neg && q[31]) || (neg && q[31] && (|q[30:0]));
    if (clamp) begin
      return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return {1'b0, neg ? (32'd0 - q) : q};
  endfunction

  // One restoring division step on a lane.
  function automatic div_lane_t div_step(div_lane_t x, logic [63:0] den);
    div_lane_t   y;
    logic [64:0] t;
    logic [64:0] d;
    t = {x.rem, x.lo[31]};
    d = {1'b0, den};
    y.lo = {x.lo[30:0], 1'b0};
    if (t >= d) begin
      y.rem = 64'(t - d);
      y.quo = {x.quo[30:0], 1'b1};
    end else begin
      y.rem = t[63:0];
      y.quo = {x.quo[30:0], 1'b0};
    end
    return y;
  endfunction

  // One digit-by-digit square root step, two radicand bits per step.
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t x);
    sqrt_lane_t  y;
    logic [35:0] t;
    logic [35:0] trial;
    t     = {x.rem, x.rad[63:62]};
    trial = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[61:0], 2'b00};
    if (t >= trial) begin
      y.rem  = 34'(t - trial);
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = t[33:0];
      y.root = {x.root[30:0], 1'b0};
    end
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic               s1_vld_r;
  cmd_t               s1_cmd_r;
  logic signed [31:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_tuser;
      s1_ar_r  <= in_tdata[31:0];
      s1_ai_r  <= in_tdata[63:32];
      s1_br_r  <= in_tdata[95:64];
      s1_bi_r  <= in_tdata[127:96];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: six parallel 32x32 products. The modulus reuses the first two
  // multipliers for the squares of A.
  // --------------------------------------------------------------------------
  logic               s2_vld_r;
  cmd_t               s2_cmd_r;
  logic               s2_dz_r;
  logic signed [31:0] s2_ar_r, s2_ai_r, s2_br_r, s2_bi_r;
  logic signed [63:0] s2_m0_r, s2_m1_r, s2_m2_r, s2_m3_r, s2_m4_r, s2_m5_r;
  logic signed [31:0] mul0_b, mul1_b;
  logic               dz_nxt;

  always_comb begin
    mul0_b = (s1_cmd_r == CMD_MOD) ? s1_ar_r : s1_br_r;
    mul1_b = (s1_cmd_r == CMD_MOD) ? s1_ai_r : s1_bi_r;
    dz_nxt = ((s1_cmd_r == CMD_CDIV) && (s1_br_r == 32'sd0) && (s1_bi_r == 32'sd0)) ||
             ((s1_cmd_r == CMD_RDIV) && (s1_br_r == 32'sd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_dz_r  <= dz_nxt;
      s2_ar_r  <= s1_ar_r;
      s2_ai_r  <= s1_ai_r;
      s2_br_r  <= s1_br_r;
      s2_bi_r  <= s1_bi_r;
      s2_m0_r  <= s1_ar_r * mul0_b;
      s2_m1_r  <= s1_ai_r * mul1_b;
      s2_m2_r  <= s1_ar_r * s1_bi_r;
      s2_m3_r  <= s1_ai_r * s1_br_r;
      s2_m4_r  <= s1_br_r * s1_br_r;
      s2_m5_r  <= s1_bi_r * s1_bi_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: exact sums per command. Products for mul and scale are floored
  // here by an arithmetic shift; division numerators stay exact.
  // --------------------------------------------------------------------------
  logic        s3_vld_r;
  cmd_t        s3_cmd_r;
  logic        s3_dz_r;
  logic        s3_bneg_r;
  wide_t       s3_re_r, s3_im_r;
  logic [63:0] s3_den_r, s3_rad_r;
  wide_t       re_nxt, im_nxt, tmp_re, tmp_im;
  logic [63:0] den_nxt;
  logic [32:0] babs;

  always_comb begin
    tmp_re = '0;
    tmp_im = '0;
    case (s2_cmd_r)
      CMD_ADD: begin
        re_nxt = sx32(s2_ar_r) + sx32(s2_br_r);
        im_nxt = sx32(s2_ai_r) + sx32(s2_bi_r);
      end
      CMD_SUB: begin
        re_nxt = sx32(s2_ar_r) - sx32(s2_br_r);
        im_nxt = sx32(s2_ai_r) - sx32(s2_bi_r);
      end
      CMD_MUL: begin
        tmp_re = sx64(s2_m0_r) - sx64(s2_m1_r);
        tmp_im = sx64(s2_m2_r) + sx64(s2_m3_r);
        re_nxt = tmp_re >>> FRAC_BITS;
        im_nxt = tmp_im >>> FRAC_BITS;
      end
      CMD_CDIV: begin
        re_nxt = sx64(s2_m0_r) + sx64(s2_m1_r);
        im_nxt = sx64(s2_m3_r) - sx64(s2_m2_r);
      end
      CMD_SCALE: begin
        tmp_re = sx64(s2_m0_r);
        tmp_im = sx64(s2_m3_r);
        re_nxt = tmp_re >>> FRAC_BITS;
        im_nxt = tmp_im >>> FRAC_BITS;
      end
      CMD_RDIV: begin
        re_nxt = sx32(s2_ar_r);
        im_nxt = sx32(s2_ai_r);
      end
      CMD_CONJ: begin
        re_nxt = sx32(s2_ar_r);
        im_nxt = -sx32(s2_ai_r);
      end
      default: begin
        re_nxt = '0;
        im_nxt = '0;
      end
    endcase
    babs    = s2_br_r[31] ? (33'd0 - {1'b1, s2_br_r}) : {1'b0, s2_br_r};
    den_nxt = (s2_cmd_r == CMD_RDIV) ? {31'd0, babs}
                                     : ($unsigned(s2_m4_r) + $unsigned(s2_m5_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r  <= s2_cmd_r;
      s3_dz_r   <= s2_dz_r;
      s3_bneg_r <= (s2_cmd_r == CMD_RDIV) && s2_br_r[31];
      s3_re_r   <= re_nxt;
      s3_im_r   <= im_nxt;
      s3_den_r  <= den_nxt;
      s3_rad_r  <= $unsigned(s2_m0_r) + $unsigned(s2_m1_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: saturate the direct results and take the numerator magnitudes.
  // --------------------------------------------------------------------------
  logic        s4_vld_r;
  ctrl_t       s4_ctrl_r;
  logic [63:0] s4_mag_re_r, s4_mag_im_r, s4_den_r, s4_rad_r;
  logic [32:0] sat_re, sat_im;
  wide_t       abs_re, abs_im;

  always_comb begin
    sat_re = sat_wide(s3_re_r);
    sat_im = sat_wide(s3_im_r);
    abs_re = s3_re_r[65] ? -s3_re_r : s3_re_r;
    abs_im = s3_im_r[65] ? -s3_im_r : s3_im_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctrl_r.cmd    <= s3_cmd_r;
      s4_ctrl_r.dz     <= s3_dz_r;
      s4_ctrl_r.neg_re <= s3_re_r[65] ^ s3_bneg_r;
      s4_ctrl_r.neg_im <= s3_im_r[65] ^ s3_bneg_r;
      s4_ctrl_r.ovf_re <= sat_re[32];
      s4_ctrl_r.ovf_im <= sat_im[32];
      s4_ctrl_r.dir_re <= sat_re[31:0];
      s4_ctrl_r.dir_im <= sat_im[31:0];
      s4_mag_re_r      <= abs_re[63:0];
      s4_mag_im_r      <= abs_im[63:0];
      s4_den_r         <= s3_den_r;
      s4_rad_r         <= s3_rad_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: split the scaled numerator into the initial partial remainder
  // and 32 low dividend bits. A partial remainder at or above the divisor
  // means the quotient needs more than 32 bits and will saturate.
  // --------------------------------------------------------------------------
  logic        pre_vld_r;
  ctrl_t       pre_ctrl_r;
  ctrl_t       pre_ctrl_nxt;
  iter_t       pre_r;
  logic [63:0] r0_re, r0_im, sh_re, sh_im;
  logic        big_re, big_im, is_div;

  always_comb begin
    r0_re  = s4_mag_re_r >> (32 - FRAC_BITS);
    r0_im  = s4_mag_im_r >> (32 - FRAC_BITS);
    sh_re  = s4_mag_re_r << FRAC_BITS;
    sh_im  = s4_mag_im_r << FRAC_BITS;
    big_re = r0_re >= s4_den_r;
    big_im = r0_im >= s4_den_r;
    is_div = s4_ctrl_r.cmd inside {CMD_CDIV, CMD_RDIV};
    pre_ctrl_nxt        = s4_ctrl_r;
    pre_ctrl_nxt.ovf_re = is_div ? big_re : s4_ctrl_r.ovf_re;
    pre_ctrl_nxt.ovf_im = is_div ? big_im : s4_ctrl_r.ovf_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (adv) begin
      pre_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_ctrl_r        <= pre_ctrl_nxt;
      pre_r.re.rem      <= r0_re;
      pre_r.re.lo       <= sh_re[31:0];
      pre_r.re.quo      <= '0;
      pre_r.im.rem      <= r0_im;
      pre_r.im.lo       <= sh_im[31:0];
      pre_r.im.quo      <= '0;
      pre_r.den         <= s4_den_r;
      pre_r.sq.rad      <= s4_rad_r;
      pre_r.sq.rem      <= '0;
      pre_r.sq.root     <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Iteration stages: each retires one quotient bit per lane and one root bit.
  // --------------------------------------------------------------------------
  logic [ITER_STAGES-1:0] it_vld_r;
  iter_t                  it_r      [ITER_STAGES];
  ctrl_t                  it_ctrl_r [ITER_STAGES];

  // The valid bits of the iteration stages form one shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_vld_r <= '0;
    end else if (adv) begin
      it_vld_r <= {it_vld_r[ITER_STAGES-2:0], pre_vld_r};
    end
  end

  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
    iter_t src;
    ctrl_t src_ctrl;

    if (k == 0) begin : g_first
      assign src      = pre_r;
      assign src_ctrl = pre_ctrl_r;
    end else begin : g_next
      assign src      = it_r[k-1];
      assign src_ctrl = it_ctrl_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[k].re    <= div_step(src.re, src.den);
        it_r[k].im    <= div_step(src.im, src.den);
        it_r[k].den   <= src.den;
        it_r[k].sq    <= sqrt_step(src.sq);
        it_ctrl_r[k]  <= src_ctrl;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: pick the result form per command, saturate, set status.
  // --------------------------------------------------------------------------
  iter_t       last;
  ctrl_t       last_ctrl;
  logic [31:0] res_re, res_im;
  stat_t       stat_nxt;
  logic [32:0] q_re, q_im;
  logic        any_ovf;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  stat_t       out_stat_r;

  always_comb begin
    last      = it_r[ITER_STAGES-1];
    last_ctrl = it_ctrl_r[ITER_STAGES-1];
    q_re      = sat_quo(last_ctrl.neg_re, last.re.quo, last_ctrl.ovf_re);
    q_im      = sat_quo(last_ctrl.neg_im, last.im.quo, last_ctrl.ovf_im);
    if (last_ctrl.cmd inside {CMD_CDIV, CMD_RDIV}) begin
      res_re  = last_ctrl.dz ? 32'd0 : q_re[31:0];
      res_im  = last_ctrl.dz ? 32'd0 : q_im[31:0];
      any_ovf = q_re[32] || q_im[32];
    end else if (last_ctrl.cmd == CMD_MOD) begin
      res_re  = last.sq.root[31] ? 32'h7FFF_FFFF : last.sq.root;
      res_im  = 32'd0;
      any_ovf = last.sq.root[31];
    end else begin
      res_re  = last_ctrl.dir_re;
      res_im  = last_ctrl.dir_im;
      any_ovf = last_ctrl.ovf_re || last_ctrl.ovf_im;
    end
    if (last_ctrl.dz) begin
      stat_nxt = STAT_DZ;
    end else if (any_ovf) begin
      stat_nxt = STAT_SAT;
    end else begin
      stat_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= it_vld_r[ITER_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {res_im, res_re};
      out_stat_r <= stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_DZ) |-> (out_tdata == 64'd0))
    else $error("divide by zero result is not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_SAT) |->
      (out_tdata[31:0] == 32'h7FFF_FFFF) || (out_tdata[31:0] == 32'h8000_0000) ||
      (out_tdata[63:32] == 32'h7FFF_FFFF) || (out_tdata[63:32] == 32'h8000_0000))
    else $error("saturation status without a clamped part");

  a_mod_im_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && it_vld_r[ITER_STAGES-1] && (last_ctrl.cmd == CMD_MOD) |=>
      (out_tdata[63:32] == 32'd0))
    else $error("modulus with nonzero imaginary part");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(it_vld_r) && $stable(pre_vld_r))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
